// ===== src/mtc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the magnetic tag classifier.
// Used by every pipeline stage and by the top level; depends on nothing.
package mtc_pkg;

   // Widths of the transaction fields.
   localparam int AngleWidth  = 9;
   localparam int GainWidth   = 8;
   localparam int SumWidth    = 9;
   localparam int DigitWidth  = 5;
   localparam int OrientWidth = 3;
   localparam int IdWidth     = 6;
   localparam int FaceWidth   = 4;

   // Packed bus widths (data padded to whole bytes).
   localparam int ReqDataWidth = 40;
   localparam int RspDataWidth = 32;
   localparam int CsrDataWidth = 32;
   localparam int CsrAddrWidth = 3;

   // Register map: word index taken from paddr[2].
   localparam logic CSR_STRENGTH_LIMIT = 1'b0;
   localparam logic [SumWidth-1:0] STRENGTH_LIMIT_RESET = 9'd450;

   // Quantizer constants.
   localparam logic [GainWidth-1:0]  GAIN_FULL    = 8'd255;
   localparam logic [AngleWidth-1:0] ANGLE_LOW    = 9'd6;
   localparam logic [AngleWidth-1:0] ANGLE_HIGH   = 9'd354;
   localparam logic [AngleWidth:0]   ANGLE_OFFSET = 10'd18;
   // (x / 4) * 171 / 512 equals x / 12 for the angles that reach the divider.
   localparam logic [7:0]            RECIP_THREE  = 8'd171;

   // Digit codes with a meaning of their own.
   localparam logic [DigitWidth-1:0] DIGIT_ZERO     = 5'd0;
   localparam logic [DigitWidth-1:0] DIGIT_NEAR     = 5'd1;
   localparam logic [DigitWidth-1:0] DIGIT_TWO      = 5'd2;
   localparam logic [DigitWidth-1:0] DIGIT_PURPLE   = 5'd5;
   localparam logic [DigitWidth-1:0] DIGIT_PID_LO   = 5'd8;
   localparam logic [DigitWidth-1:0] DIGIT_PID_HI   = 5'd10;
   localparam logic [DigitWidth-1:0] DIGIT_PMARK_LO = 5'd15;
   localparam logic [DigitWidth-1:0] DIGIT_ID_HI    = 5'd17;
   localparam logic [DigitWidth-1:0] DIGIT_FACE_LO  = 5'd17;
   localparam logic [DigitWidth-1:0] DIGIT_FACE_REAL = 5'd18;
   localparam logic [DigitWidth-1:0] DIGIT_SLEEP    = 5'd25;
   localparam logic [DigitWidth-1:0] DIGIT_FACE_HI  = 5'd29;
   localparam logic [DigitWidth-1:0] DIGIT_PLOW_TOP = 5'd30;

   typedef enum logic [2:0] {
      KIND_NOTHING = 3'd0,
      KIND_INVALID = 3'd1,
      KIND_REGULAR = 3'd2,
      KIND_PASSIVE = 3'd3,
      KIND_COMMAND = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_SLEEP  = 2'd1,
      CMD_PURPLE = 2'd2
   } cmd_type;

   // Orientation codes.
   localparam logic signed [OrientWidth-1:0] ORIENT_NONE = -3'sd1;
   localparam logic signed [OrientWidth-1:0] ORIENT_0    = 3'sd0;
   localparam logic signed [OrientWidth-1:0] ORIENT_1    = 3'sd1;
   localparam logic signed [OrientWidth-1:0] ORIENT_2    = 3'sd2;
   localparam logic signed [OrientWidth-1:0] ORIENT_3    = 3'sd3;

   localparam logic signed [IdWidth-1:0]   ID_NONE   = -6'sd1;
   localparam logic signed [FaceWidth-1:0] FACE_NONE = -4'sd1;

   typedef logic [DigitWidth-1:0] digit_type;

   // Stage 1 output: both digits and the strength sum.
   typedef struct packed {
      digit_type             digit_a;
      digit_type             digit_b;
      logic [SumWidth-1:0]   sum;
   } quant_type;

   // Classification of one digit.
   typedef struct packed {
      digit_type                    value;
      logic                         is_face;
      logic                         is_id;
      logic                         odd;
      logic                         pmark;
      logic                         plow;
      logic                         pid;
      logic signed [FaceWidth-1:0]  face;
   } flags_type;

   // Stage 2 output.
   typedef struct packed {
      flags_type            fa;
      flags_type            fb;
      logic                 absent;
      logic                 same;
      cmd_type              cmd;
      logic [SumWidth-1:0]  sum;
   } decode_type;

   // Final result.
   typedef struct packed {
      kind_type                       kind;
      logic signed [OrientWidth-1:0]  orientation;
      logic signed [IdWidth-1:0]      module_id;
      logic signed [FaceWidth-1:0]    face_number;
      cmd_type                        command;
      logic [SumWidth-1:0]            sum;
   } result_type;

endpackage

// ===== src/mtc_quantize.sv =====
`timescale 1ns / 1ps
// Stage 1: quantizes both sensor readings to digits and sums the gains.
// Depends on mtc_pkg.
module mtc_quantize (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         advance,
   input  logic [mtc_pkg::AngleWidth-1:0] angle_a,
   input  logic [mtc_pkg::GainWidth-1:0]  gain_a,
   input  logic [mtc_pkg::AngleWidth-1:0] angle_b,
   input  logic [mtc_pkg::GainWidth-1:0]  gain_b,
   output logic                         out_valid,
   output mtc_pkg::quant_type           out_data
);
   import mtc_pkg::*;

   logic      valid_ff;
   quant_type data_ff;
   quant_type data_in;

   // Digit of one reading; the divide by twelve is a shift and a multiply.
   function automatic digit_type quantize(input logic [AngleWidth-1:0] angle,
                                          input logic [GainWidth-1:0] gain);
      logic [AngleWidth:0] shifted;
      logic [15:0]         prod;
      digit_type           d;
      shifted = {1'b0, angle} + ANGLE_OFFSET;
      prod    = {8'd0, shifted[AngleWidth:2]} * {8'd0, RECIP_THREE};
      if ((gain == '0) || (gain == GAIN_FULL)) begin
         d = DIGIT_ZERO;
      end else if ((angle < ANGLE_LOW) || (angle > ANGLE_HIGH)) begin
         d = DIGIT_NEAR;
      end else begin
         d = prod[13:9];
      end
      return d;
   endfunction

   always_comb begin
      data_in.digit_a = quantize(angle_a, gain_a);
      data_in.digit_b = quantize(angle_b, gain_b);
      data_in.sum     = {1'b0, gain_a} + {1'b0, gain_b};
   end

   // Valid register follows the stage enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/mtc_decode.sv =====
`timescale 1ns / 1ps
// Stage 2: classifies each digit and checks the strength window.
// Depends on mtc_pkg.
module mtc_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         advance,
   input  mtc_pkg::quant_type           in_data,
   input  logic [mtc_pkg::SumWidth-1:0] strength_limit,
   output logic                         out_valid,
   output mtc_pkg::decode_type          out_data
);
   import mtc_pkg::*;

   logic       valid_ff;
   decode_type data_ff;
   decode_type data_in;

   // Per-digit membership flags and face index.
   function automatic flags_type classify(input digit_type d);
      flags_type f;
      digit_type diff;
      diff      = DIGIT_FACE_HI - d;
      f.value   = d;
      f.is_face = (d >= DIGIT_FACE_LO) && (d <= DIGIT_FACE_HI);
      f.is_id   = (d >= DIGIT_NEAR) && (d <= DIGIT_ID_HI);
      f.odd     = d[0];
      f.plow    = (d == DIGIT_PLOW_TOP) || (d == DIGIT_NEAR) || (d == DIGIT_TWO);
      f.pmark   = f.plow || ((d >= DIGIT_PMARK_LO) && (d <= DIGIT_ID_HI));
      f.pid     = (d >= DIGIT_PID_LO) && (d <= DIGIT_PID_HI);
      if ((d >= DIGIT_FACE_REAL) && (d <= DIGIT_FACE_HI)) begin
         f.face = {1'b0, diff[3:1]};
      end else begin
         f.face = FACE_NONE;
      end
      return f;
   endfunction

   always_comb begin
      data_in.fa     = classify(in_data.digit_a);
      data_in.fb     = classify(in_data.digit_b);
      data_in.absent = (in_data.sum > strength_limit) || (in_data.sum == '0);
      data_in.same   = (in_data.digit_a == in_data.digit_b) &&
                       (in_data.digit_a != DIGIT_ID_HI) &&
                       (in_data.digit_a != DIGIT_PLOW_TOP);
      case (in_data.digit_a)
         DIGIT_SLEEP:  data_in.cmd = CMD_SLEEP;
         DIGIT_PURPLE: data_in.cmd = CMD_PURPLE;
         default:      data_in.cmd = CMD_NONE;
      endcase
      data_in.sum = in_data.sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/mtc_resolve.sv =====
`timescale 1ns / 1ps
// Stage 3: applies the ordered tag rules and holds the result register.
// Depends on mtc_pkg.
module mtc_resolve (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 advance,
   input  mtc_pkg::decode_type  in_data,
   output logic                 out_valid,
   output mtc_pkg::result_type  out_data
);
   import mtc_pkg::*;

   logic       valid_ff;
   result_type data_ff;
   result_type data_in;

   // Rules run in order; later ones overwrite, passive ones only kind and orientation.
   always_comb begin
      data_in.kind        = KIND_NOTHING;
      data_in.orientation = ORIENT_NONE;
      data_in.module_id   = ID_NONE;
      data_in.face_number = FACE_NONE;
      data_in.command     = CMD_NONE;
      data_in.sum         = in_data.sum;
      if (!in_data.absent) begin
         data_in.kind = KIND_INVALID;
         if (in_data.fa.is_face && in_data.fb.is_id) begin
            data_in.kind        = KIND_REGULAR;
            data_in.module_id   = {1'b0, in_data.fb.value};
            data_in.face_number = in_data.fa.face;
            data_in.orientation = in_data.fa.odd ? ORIENT_1 : ORIENT_0;
         end
         if (in_data.fb.is_face && in_data.fa.is_id) begin
            data_in.kind        = KIND_REGULAR;
            data_in.module_id   = {1'b0, in_data.fa.value};
            data_in.face_number = in_data.fb.face;
            data_in.orientation = in_data.fb.odd ? ORIENT_3 : ORIENT_2;
         end
         if (in_data.fa.pmark && in_data.fb.pid) begin
            data_in.kind        = KIND_PASSIVE;
            data_in.orientation = in_data.fa.plow ? ORIENT_2 : ORIENT_3;
         end
         if (in_data.fb.pmark && in_data.fa.pid) begin
            data_in.kind        = KIND_PASSIVE;
            data_in.orientation = in_data.fb.plow ? ORIENT_0 : ORIENT_1;
         end
         if (in_data.same) begin
            data_in.kind    = KIND_COMMAND;
            data_in.command = in_data.cmd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // A regular module always carries an id digit.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && (data_ff.kind == KIND_REGULAR) |->
         (data_ff.module_id >= 6'sd1) && (data_ff.module_id <= 6'sd17))
      else $error("regular module without id");

   // Only command tags carry a command code.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && (data_ff.command != CMD_NONE) |-> (data_ff.kind == KIND_COMMAND))
      else $error("command code on non-command tag");

   // An absent tag reports no fields.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && (data_ff.kind == KIND_NOTHING) |->
         (data_ff.orientation == ORIENT_NONE) && (data_ff.module_id == ID_NONE) &&
         (data_ff.face_number == FACE_NONE))
      else $error("absent tag with fields set");

endmodule

// ===== src/magnetic_tag_classifier_top.sv =====
`timescale 1ns / 1ps
// An accepted request passes the quantize, decode and resolve registers to rsp_tvalid.
// Throughput: one transaction per cycle unless rsp_tready stalls; each of the three
// stages holds one item and moves when the stage after it is empty or moving.
// Reset: synchronous, clears all stage valid bits and sets strength_limit to 450.
// Top level of the magnetic tag classifier; depends on mtc_pkg and the stage modules.
module magnetic_tag_classifier_top (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // angle_a[8:0], gain_a[16:9], angle_b[25:17], gain_b[33:26], zero [39:34]
   input  logic [mtc_pkg::ReqDataWidth-1:0]  req_tdata,
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tag_kind[2:0], orientation[5:3], module_id[11:6], face_number[15:12],
   // command_code[17:16], strength_sum[26:18], zero [31:27]
   output logic [mtc_pkg::RspDataWidth-1:0]  rsp_tdata,
   // Configuration port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mtc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [mtc_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [mtc_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import mtc_pkg::*;

   logic [SumWidth-1:0] strength_limit_ff;
   logic                csr_write;

   logic       s1_valid, s2_valid, s3_valid;
   logic       s1_advance, s2_advance, s3_advance;
   quant_type  s1_data;
   decode_type s2_data;
   result_type s3_data;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_limit_ff <= STRENGTH_LIMIT_RESET;
      end else if (csr_write && (csr_paddr[2] == CSR_STRENGTH_LIMIT)) begin
         strength_limit_ff <= csr_pwdata[SumWidth-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == CSR_STRENGTH_LIMIT) begin
         csr_prdata = {{(CsrDataWidth-SumWidth){1'b0}}, strength_limit_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // Stage enables: a stage moves when it is empty or the next one moves.
   assign s3_advance = !s3_valid || rsp_tready;
   assign s2_advance = !s2_valid || s3_advance;
   assign s1_advance = !s1_valid || s2_advance;
   assign req_tready = s1_advance;

   mtc_quantize u_quantize (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .advance   (s1_advance),
      .angle_a   (req_tdata[8:0]),
      .gain_a    (req_tdata[16:9]),
      .angle_b   (req_tdata[25:17]),
      .gain_b    (req_tdata[33:26]),
      .out_valid (s1_valid),
      .out_data  (s1_data)
   );

   mtc_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s1_valid),
      .advance        (s2_advance),
      .in_data        (s1_data),
      .strength_limit (strength_limit_ff),
      .out_valid      (s2_valid),
      .out_data       (s2_data)
   );

   mtc_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .advance   (s3_advance),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_data  (s3_data)
   );

   // Response packing.
   assign rsp_tvalid = s3_valid;
   assign rsp_tdata  = {5'd0, s3_data.sum, s3_data.command, s3_data.face_number,
                        s3_data.module_id, s3_data.orientation, s3_data.kind};

   // The request side only stalls when a finished result is held back.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without back-pressure");

   // An item accepted while rsp_tready stays high moves through every stage to the output.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tready ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("accepted transaction did not reach the output");

   // A held result stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

// ===== dv/tb_magnetic_tag_classifier_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for magnetic_tag_classifier_top: drives sensor readings,
// predicts each tag result and compares it field by field. Depends on mtc_pkg and the RTL.
module tb_magnetic_tag_classifier_top;
   import mtc_pkg::*;

   localparam int ClockPeriod     = 10;
   localparam int StallLimit      = 2000;
   localparam int HoldoffCycles   = 250;
   localparam int IdlePercent     = 35;
   localparam int DrainCycles     = 8;
   localparam int DegreesPerDigit = 12;
   localparam int MaxPrinted      = 40;
   localparam int TopDigit        = 31;
   localparam logic [CsrAddrWidth-1:0] LimitAddr  = 3'd0;
   localparam logic [CsrAddrWidth-1:0] UnusedAddr = 3'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic csr_pready;

   // Testbench copy of the strength limit register.
   logic [SumWidth-1:0] limit_copy = STRENGTH_LIMIT_RESET;
   result_type expected_tags[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit full_rate = 1'b0;
   bit holdoff_pending = 1'b0;
   int holdoff_left = 0;

   magnetic_tag_classifier_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // Quantize one reading into its digit.
   function automatic int reading_digit(input logic [AngleWidth-1:0] angle,
                                        input logic [GainWidth-1:0] gain);
      if (gain == 0 || gain == GAIN_FULL) return int'(DIGIT_ZERO);
      if (angle < ANGLE_LOW || angle > ANGLE_HIGH) return int'(DIGIT_NEAR);
      return (int'(angle) + int'(ANGLE_OFFSET)) / DegreesPerDigit;
   endfunction

   function automatic int face_index(input int d);
      if (d >= int'(DIGIT_FACE_REAL) && d <= int'(DIGIT_FACE_HI))
         return (int'(DIGIT_FACE_HI) - d) / 2;
      return -1;
   endfunction

   function automatic bit is_face_digit(input int d);
      return d >= int'(DIGIT_FACE_LO) && d <= int'(DIGIT_FACE_HI);
   endfunction

   function automatic bit is_id_digit(input int d);
      return d >= int'(DIGIT_NEAR) && d <= int'(DIGIT_ID_HI);
   endfunction

   function automatic bit is_low_mark(input int d);
      return d == int'(DIGIT_PLOW_TOP) || d == int'(DIGIT_NEAR) || d == int'(DIGIT_TWO);
   endfunction

   function automatic bit is_passive_mark(input int d);
      return is_low_mark(d) || (d >= int'(DIGIT_PMARK_LO) && d <= int'(DIGIT_ID_HI));
   endfunction

   function automatic bit is_passive_id(input int d);
      return d >= int'(DIGIT_PID_LO) && d <= int'(DIGIT_PID_HI);
   endfunction

   // Predict the tag result for one pair of readings under the current limit.
   function automatic result_type classify_reading(input logic [ReqDataWidth-1:0] data);
      int d1;
      int d2;
      int sum;
      result_type r;
      d1 = reading_digit(data[8:0], data[16:9]);
      d2 = reading_digit(data[25:17], data[33:26]);
      sum = int'(data[16:9]) + int'(data[33:26]);
      r.kind = KIND_NOTHING;
      r.orientation = ORIENT_NONE;
      r.module_id = ID_NONE;
      r.face_number = FACE_NONE;
      r.command = CMD_NONE;
      r.sum = sum[SumWidth-1:0];
      if (sum != 0 && sum <= int'(limit_copy)) begin
         r.kind = KIND_INVALID;
         // Regular module, face digit on the first sensor.
         if (is_face_digit(d1) && is_id_digit(d2)) begin
            r.kind = KIND_REGULAR;
            r.module_id = IdWidth'(d2);
            r.face_number = FaceWidth'(face_index(d1));
            r.orientation = (d1 % 2 == 0) ? ORIENT_0 : ORIENT_1;
         end
         // Regular module, face digit on the second sensor.
         if (is_face_digit(d2) && is_id_digit(d1)) begin
            r.kind = KIND_REGULAR;
            r.module_id = IdWidth'(d1);
            r.face_number = FaceWidth'(face_index(d2));
            r.orientation = (d2 % 2 == 0) ? ORIENT_2 : ORIENT_3;
         end
         // Passive modules only change kind and orientation.
         if (is_passive_mark(d1) && is_passive_id(d2)) begin
            r.kind = KIND_PASSIVE;
            r.orientation = is_low_mark(d1) ? ORIENT_2 : ORIENT_3;
         end
         if (is_passive_mark(d2) && is_passive_id(d1)) begin
            r.kind = KIND_PASSIVE;
            r.orientation = is_low_mark(d2) ? ORIENT_0 : ORIENT_1;
         end
         // Command tags: both digits equal, except the two reserved ones.
         if (d1 == d2 && d1 != int'(DIGIT_ID_HI) && d1 != int'(DIGIT_PLOW_TOP)) begin
            r.kind = KIND_COMMAND;
            if (d1 == int'(DIGIT_SLEEP)) r.command = CMD_SLEEP;
            if (d1 == int'(DIGIT_PURPLE)) r.command = CMD_PURPLE;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= MaxPrinted)
         $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Record each accepted request and check each accepted response.
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) expected_tags.push_back(classify_reading(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tags.size() == 0) begin
               report_mismatch("unexpected response", int'(rsp_tdata), 0);
            end else begin
               want = expected_tags.pop_front();
               if (rsp_tdata[2:0] !== want.kind)
                  report_mismatch("tag_kind", int'(rsp_tdata[2:0]), int'(want.kind));
               if (rsp_tdata[5:3] !== want.orientation)
                  report_mismatch("orientation", int'($signed(rsp_tdata[5:3])),
                                  int'(want.orientation));
               if (rsp_tdata[11:6] !== want.module_id)
                  report_mismatch("module_id", int'($signed(rsp_tdata[11:6])),
                                  int'(want.module_id));
               if (rsp_tdata[15:12] !== want.face_number)
                  report_mismatch("face_number", int'($signed(rsp_tdata[15:12])),
                                  int'(want.face_number));
               if (rsp_tdata[17:16] !== want.command)
                  report_mismatch("command_code", int'(rsp_tdata[17:16]), int'(want.command));
               if (rsp_tdata[26:18] !== want.sum)
                  report_mismatch("strength_sum", int'(rsp_tdata[26:18]), int'(want.sum));
               if (rsp_tdata[31:27] !== '0)
                  report_mismatch("padding", int'(rsp_tdata[31:27]), 0);
            end
         end
      end
   end

   // Receiver: random stalls, full rate on request, and a long counted hold-off.
   always @(posedge clock) begin
      if (holdoff_pending) begin
         holdoff_left = HoldoffCycles;
         holdoff_pending = 1'b0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= full_rate || ($urandom_range(99) >= IdlePercent);
      end
   end

   // Watchdog on cycles with no transaction at all.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= StallLimit) begin
         $display("[%0t] watchdog: no transaction for %0d cycles", $time, StallLimit);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one reading and hold it until accepted, then maybe idle a while.
   task automatic send_reading(input logic [AngleWidth-1:0] angle_a,
                               input logic [GainWidth-1:0] gain_a,
                               input logic [AngleWidth-1:0] angle_b,
                               input logic [GainWidth-1:0] gain_b);
      req_tvalid <= 1'b1;
      req_tdata <= {{(ReqDataWidth - 34){1'b0}}, gain_b, angle_b, gain_a, angle_a};
      do @(posedge clock); while (!req_tready);
      if (!full_rate && $urandom_range(99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every expected response has arrived.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_tags.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrAddrWidth-1:0] addr,
                            input logic [CsrDataWidth-1:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == LimitAddr) limit_copy = data[SumWidth-1:0];
      @(posedge clock);
   endtask

   // Read the limit register back and compare it with the local copy.
   task automatic check_limit_readback();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= LimitAddr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[SumWidth-1:0] !== limit_copy)
         report_mismatch("strength_limit readback", int'(csr_prdata[SumWidth-1:0]),
                         int'(limit_copy));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [AngleWidth-1:0] angle_for_digit(input int d);
      if (d == int'(DIGIT_ZERO)) return AngleWidth'($urandom_range(511));
      if (d == int'(DIGIT_NEAR))
         return $urandom_range(1) ? AngleWidth'($urandom_range(int'(ANGLE_LOW) - 1))
                                  : AngleWidth'($urandom_range(511, int'(ANGLE_HIGH) + 1));
      if (d == TopDigit) return ANGLE_HIGH;
      return AngleWidth'(DegreesPerDigit * d - int'(ANGLE_OFFSET) +
                         $urandom_range(DegreesPerDigit - 1));
   endfunction

   // Gains mostly small enough for the sum to stay within the current limit.
   function automatic logic [GainWidth-1:0] gain_for_digit(input int d);
      int cap;
      if (d == int'(DIGIT_ZERO)) return $urandom_range(1) ? GAIN_FULL : '0;
      cap = int'(limit_copy) / 2;
      if (cap > 254 || $urandom_range(99) < 15) cap = 254;
      if (cap < 1) cap = 1;
      return GainWidth'($urandom_range(1, cap));
   endfunction

   function automatic int pick_passive_mark();
      case ($urandom_range(5))
         0: return int'(DIGIT_PMARK_LO);
         1: return int'(DIGIT_PMARK_LO) + 1;
         2: return int'(DIGIT_ID_HI);
         3: return int'(DIGIT_PLOW_TOP);
         4: return int'(DIGIT_NEAR);
         default: return int'(DIGIT_TWO);
      endcase
   endfunction

   // Mostly well-formed tag patterns with random content, the rest raw noise.
   task automatic send_random_reading();
      int pick;
      int d1;
      int d2;
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_reading(AngleWidth'($urandom_range(511)),
                      $urandom_range(4) == 0 ? ($urandom_range(1) ? GAIN_FULL : '0)
                                             : GainWidth'($urandom_range(255)),
                      AngleWidth'($urandom_range(511)),
                      $urandom_range(4) == 0 ? ($urandom_range(1) ? GAIN_FULL : '0)
                                             : GainWidth'($urandom_range(255)));
      end else begin
         if (pick < 45) begin
            d1 = $urandom_range(int'(DIGIT_FACE_HI), int'(DIGIT_FACE_LO));
            d2 = $urandom_range(int'(DIGIT_ID_HI), int'(DIGIT_NEAR));
         end else if (pick < 60) begin
            d1 = $urandom_range(int'(DIGIT_ID_HI), int'(DIGIT_NEAR));
            d2 = $urandom_range(int'(DIGIT_FACE_HI), int'(DIGIT_FACE_LO));
         end else if (pick < 68) begin
            d1 = pick_passive_mark();
            d2 = $urandom_range(int'(DIGIT_PID_HI), int'(DIGIT_PID_LO));
         end else if (pick < 76) begin
            d1 = $urandom_range(int'(DIGIT_PID_HI), int'(DIGIT_PID_LO));
            d2 = pick_passive_mark();
         end else if (pick < 88) begin
            case ($urandom_range(2))
               0: d1 = int'(DIGIT_SLEEP);
               1: d1 = int'(DIGIT_PURPLE);
               default: d1 = $urandom_range(TopDigit);
            endcase
            d2 = d1;
         end else begin
            d1 = $urandom_range(TopDigit);
            d2 = $urandom_range(TopDigit);
         end
         send_reading(angle_for_digit(d1), gain_for_digit(d1),
                      angle_for_digit(d2), gain_for_digit(d2));
      end
   endtask

   task automatic run_random_readings(input int count);
      repeat (count) send_random_reading();
      wait_idle();
   endtask

   task automatic test_reset_value();
      check_limit_readback();
   endtask

   // Field extremes, every tag kind and each corner of the rules.
   task automatic test_directed();
      send_reading(9'd0, 8'd0, 9'd0, 8'd0);          // zero strength: nothing
      send_reading(9'd511, 8'd254, 9'd511, 8'd254);  // above the limit: nothing
      send_reading(9'd100, 8'd255, 9'd200, 8'd0);    // both digits zero: bare command
      send_reading(9'd300, 8'd255, 9'd7, 8'd255);    // saturated gains, sum above limit
      send_reading(9'd330, 8'd100, 9'd0, 8'd100);    // regular, face on first sensor
      send_reading(9'd198, 8'd90, 9'd186, 8'd80);    // regular, highest id
      send_reading(9'd42, 8'd70, 9'd318, 8'd60);     // regular, face on second sensor
      send_reading(9'd186, 8'd50, 9'd18, 8'd40);     // face digit 17 leaves face unknown
      send_reading(9'd190, 8'd30, 9'd187, 8'd30);    // both sensors on digit 17
      send_reading(9'd342, 8'd77, 9'd90, 8'd66);     // passive, low mark first
      send_reading(9'd78, 8'd120, 9'd174, 8'd110);   // passive, high mark second
      send_reading(9'd102, 8'd33, 9'd186, 8'd44);    // passive overrides regular, keeps id
      send_reading(9'd400, 8'd11, 9'd80, 8'd22);     // out-of-range angle counts as near zero
      send_reading(9'd282, 8'd60, 9'd293, 8'd70);    // sleep command
      send_reading(9'd42, 8'd5, 9'd53, 8'd6);        // purple command
      send_reading(9'd342, 8'd100, 9'd353, 8'd100);  // equal digit 30 stays invalid
      send_reading(9'd354, 8'd100, 9'd354, 8'd100);  // top digit on both sensors
      send_reading(9'd5, 8'd1, 9'd355, 8'd1);        // near zero on both edges
      send_reading(9'd6, 8'd128, 9'd360, 8'd64);     // lowest real digit: invalid
      send_reading(9'd222, 8'd225, 9'd20, 8'd225);   // sum equal to the limit
      send_reading(9'd256, 8'd254, 9'd255, 8'd196);  // sum equal to the limit again
      send_reading(9'd511, 8'd170, 9'd256, 8'd85);   // upper angle bits
      wait_idle();
   endtask

   task automatic test_random_readings();
      run_random_readings(400);
   endtask

   // Both sides at full rate for a long stretch.
   task automatic test_full_rate();
      full_rate = 1'b1;
      run_random_readings(200);
      full_rate = 1'b0;
   endtask

   // Receiver holds off while the sender keeps offering, so the pipeline fills.
   task automatic test_backpressure();
      full_rate = 1'b1;
      holdoff_pending = 1'b1;
      run_random_readings(60);
      full_rate = 1'b0;
   endtask

   // Several limit settings, the extremes among them.
   task automatic test_strength_limit_sweep();
      logic [SumWidth-1:0] limits[5];
      limits = '{9'd0, 9'd510, 9'd1, 9'd255, SumWidth'($urandom_range(2, 509))};
      foreach (limits[i]) begin
         csr_write(LimitAddr, {CsrDataWidth'($urandom) >> SumWidth << SumWidth} | limits[i]);
         check_limit_readback();
         run_random_readings(100);
      end
   endtask

   // A write outside the register map must leave the limit untouched.
   task automatic test_unused_register();
      csr_write(UnusedAddr, CsrDataWidth'($urandom));
      check_limit_readback();
      run_random_readings(30);
   endtask

   task automatic test_restore_default();
      csr_write(LimitAddr, CsrDataWidth'(STRENGTH_LIMIT_RESET));
      check_limit_readback();
      run_random_readings(100);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_value();
      test_directed();
      test_random_readings();
      test_full_rate();
      test_backpressure();
      test_strength_limit_sweep();
      test_unused_register();
      test_restore_default();
      if (error_count == 0 && expected_tags.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
